// ===== hw/rtl/dlh_pkg.sv =====
// Shared types and constants for the digitizer level histogram unit.
package dlh_pkg;

  localparam int NUM_BINS    = 256;
  localparam int BIN_W       = 8;
  localparam int OUT_W       = 48;
  localparam int MAX_SAMPLES = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] MASK_2BIT = 8'h03;
  localparam logic [7:0] MASK_4BIT = 8'h0f;

  localparam logic [1:0] MODE_2BIT  = 2'd0;
  localparam logic [1:0] MODE_4BIT  = 2'd1;
  localparam logic [1:0] MODE_8BIT  = 2'd2;
  localparam logic [1:0] MODE_RESET = MODE_8BIT;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    op_t                                op;
    logic [1:0]                         dig;
    logic                               dig_ok;
    logic [MAX_SAMPLES-1:0][BIN_W-1:0]  levels;
    logic [2:0]                         nsamp;
    logic [BIN_W-1:0]                   bin;
    logic                               bad;
  } cmd_t;

endpackage

// ===== hw/rtl/dlh_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module dlh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/dlh_front.sv =====
// Front end: mode register, item classification and the command queue.
module dlh_front #(
  parameter int NUM_DIGITIZERS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    op,
  input  logic [1:0]    digitizer,
  input  logic [7:0]    data_byte,
  input  logic [7:0]    bin_index,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_data,
  input  logic          busy,
  output logic          head_valid,
  output dlh_pkg::cmd_t head,
  input  logic          head_pop
);
  import dlh_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [1:0]       sample_mode;
  cmd_t             cmd;
  logic             keep;
  logic             enq;
  logic             deq;
  cmd_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mode <= MODE_RESET;
    end else if (cfg_valid) begin
      sample_mode <= cfg_data;
    end
  end

  // Split the byte into levels and flag read bins outside the current mode.
  always_comb begin
    cmd        = '0;
    cmd.op     = op_t'(op);
    cmd.dig    = digitizer;
    cmd.dig_ok = 7'(digitizer) < 7'(NUM_DIGITIZERS);
    cmd.bin    = bin_index;
    unique case (sample_mode)
      MODE_2BIT: begin
        cmd.levels[0] = data_byte & MASK_2BIT;
        cmd.levels[1] = (data_byte >> 2) & MASK_2BIT;
        cmd.levels[2] = (data_byte >> 4) & MASK_2BIT;
        cmd.levels[3] = (data_byte >> 6) & MASK_2BIT;
        cmd.nsamp     = 3'd4;
        cmd.bad       = |bin_index[7:2];
      end
      MODE_4BIT: begin
        cmd.levels[0] = data_byte & MASK_4BIT;
        cmd.levels[1] = (data_byte >> 4) & MASK_4BIT;
        cmd.nsamp     = 3'd2;
        cmd.bad       = |bin_index[7:4];
      end
      default: begin
        cmd.levels[0] = data_byte;
        cmd.nsamp     = 3'd1;
        cmd.bad       = 1'b0;
      end
    endcase
  end

  // Items that change nothing and return nothing are taken and dropped here.
  always_comb begin
    unique case (cmd.op)
      OP_COUNT: keep = cmd.dig_ok;
      OP_READ:  keep = 1'b1;
      OP_CLEAR: keep = cmd.dig_ok;
      default:  keep = 1'b0;
    endcase
  end

  assign full       = (count == (PTR_W+1)'(QUEUE_DEPTH)) || busy;
  assign enq        = push && !full && keep;
  assign head_valid = (count != '0);
  assign head       = q_mem[rd_ptr];
  assign deq        = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        q_mem[wr_ptr] <= cmd;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/dlh_back.sv =====
// Back end: counter memories, update sequencer, clear sweeps and result register.
module dlh_back #(
  parameter int NUM_DIGITIZERS = 4,
  parameter int COUNT_WIDTH    = 48
) (
  input  logic                       clk,
  input  logic                       rst,
  output logic                       busy,
  input  logic                       head_valid,
  input  dlh_pkg::cmd_t              head,
  output logic                       head_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [dlh_pkg::OUT_W-1:0]  level_count,
  output logic [dlh_pkg::OUT_W-1:0]  sample_total,
  output logic                       bad_bin
);
  import dlh_pkg::*;

  localparam int LVL_DEPTH = NUM_DIGITIZERS * NUM_BINS;
  localparam int ADDR_W    = $clog2(LVL_DEPTH);
  localparam int TOT_AW    = (NUM_DIGITIZERS > 1) ? $clog2(NUM_DIGITIZERS) : 1;
  localparam int CW        = COUNT_WIDTH;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CNT_WR,
    S_CNT_RD,
    S_RD_OUT,
    S_CLR
  } state_t;

  state_t            state;
  cmd_t              cmd;
  logic [1:0]        k;
  logic [BIN_W-1:0]  clr_ctr;
  logic [ADDR_W-1:0] init_ctr;
  logic              out_valid;

  logic              lvl_we;
  logic [ADDR_W-1:0] lvl_waddr;
  logic [CW-1:0]     lvl_wdata;
  logic [ADDR_W-1:0] lvl_raddr;
  logic [CW-1:0]     lvl_rdata;
  logic              tot_we;
  logic [TOT_AW-1:0] tot_waddr;
  logic [CW-1:0]     tot_wdata;
  logic [TOT_AW-1:0] tot_raddr;
  logic [CW-1:0]     tot_rdata;
  logic [CW:0]       lvl_sum;
  logic [CW:0]       tot_sum;
  logic              last_sample;

  function automatic logic [ADDR_W-1:0] lvl_addr(input logic [1:0] d,
                                                input logic [BIN_W-1:0] l);
    logic [15:0] f;
    f = {6'b0, d, l};
    return f[ADDR_W-1:0];
  endfunction

  function automatic logic [TOT_AW-1:0] tot_addr(input logic [1:0] d);
    logic [7:0] f;
    f = {6'b0, d};
    return f[TOT_AW-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input logic [CW-1:0] v);
    logic [OUT_W+CW-1:0] f;
    f = {{OUT_W{1'b0}}, v};
    return f[OUT_W-1:0];
  endfunction

  dlh_ram #(.WIDTH(CW), .DEPTH(LVL_DEPTH)) u_lvl_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wdata),
    .raddr (lvl_raddr),
    .rdata (lvl_rdata)
  );

  dlh_ram #(.WIDTH(CW), .DEPTH(NUM_DIGITIZERS)) u_tot_ram (
    .clk   (clk),
    .we    (tot_we),
    .waddr (tot_waddr),
    .wdata (tot_wdata),
    .raddr (tot_raddr),
    .rdata (tot_rdata)
  );

  // Saturating increments: a carry out of the counter width means overflow.
  assign lvl_sum     = {1'b0, lvl_rdata} + (CW+1)'(1);
  assign tot_sum     = {1'b0, tot_rdata} + (CW+1)'(cmd.nsamp);
  assign last_sample = ({1'b0, k} == cmd.nsamp - 3'd1);

  assign busy     = (state == S_INIT);
  assign head_pop = (state == S_IDLE) && head_valid && ((head.op != OP_READ) || !out_valid);
  assign empty    = !out_valid;

  always_comb begin
    lvl_we    = 1'b0;
    lvl_waddr = lvl_addr(cmd.dig, cmd.levels[k]);
    lvl_wdata = lvl_sum[CW] ? {CW{1'b1}} : lvl_sum[CW-1:0];
    lvl_raddr = lvl_addr(cmd.dig, cmd.levels[k]);
    tot_we    = 1'b0;
    tot_waddr = tot_addr(cmd.dig);
    tot_wdata = tot_sum[CW] ? {CW{1'b1}} : tot_sum[CW-1:0];
    tot_raddr = tot_addr(head.dig);
    unique case (state)
      S_INIT: begin
        lvl_we    = 1'b1;
        lvl_waddr = init_ctr;
        lvl_wdata = '0;
        tot_we    = init_ctr < ADDR_W'(NUM_DIGITIZERS);
        tot_waddr = init_ctr[TOT_AW-1:0];
        tot_wdata = '0;
      end
      S_IDLE: begin
        lvl_raddr = (head.op == OP_READ) ? lvl_addr(head.dig, head.bin)
                                         : lvl_addr(head.dig, head.levels[0]);
      end
      S_CNT_WR: begin
        lvl_we = 1'b1;
        tot_we = (k == 2'd0);
      end
      S_CLR: begin
        lvl_we    = 1'b1;
        lvl_waddr = lvl_addr(cmd.dig, clr_ctr);
        lvl_wdata = '0;
        tot_we    = (clr_ctr == '0);
        tot_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_ctr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          init_ctr <= init_ctr + 1'b1;
          if (init_ctr == ADDR_W'(LVL_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head_pop) begin
            cmd     <= head;
            k       <= '0;
            clr_ctr <= '0;
            unique case (head.op)
              OP_COUNT: state <= S_CNT_WR;
              OP_READ:  state <= S_RD_OUT;
              OP_CLEAR: state <= S_CLR;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_CNT_WR: begin
          if (last_sample) begin
            state <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_CNT_RD;
          end
        end
        S_CNT_RD: begin
          state <= S_CNT_WR;
        end
        S_RD_OUT: begin
          out_valid    <= 1'b1;
          level_count  <= (cmd.bad || !cmd.dig_ok) ? '0 : to_out(lvl_rdata);
          sample_total <= cmd.dig_ok ? to_out(tot_rdata) : '0;
          bad_bin      <= cmd.bad;
          state        <= S_IDLE;
        end
        S_CLR: begin
          clr_ctr <= clr_ctr + 1'b1;
          if (clr_ctr == BIN_W'(NUM_BINS - 1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/digitizer_level_histogram_unit.sv =====
// Top level of the digitizer level histogram unit.
//
// This unit keeps a level histogram and a sample total for each digitizer.
// A count item splits its data byte, from the low bits up, into packed samples
// of 2, 4 or 8 bits as the sample mode register selects (mode 3 acts as 8-bit),
// and adds one to the bin of each sample and the number of samples to the
// digitizer's total. A read item returns one bin's count and the total; a bin
// at or above two to the power of the sample bits is flagged as bad and reads
// as zero. A clear item zeroes one digitizer's bins and total. All counters
// saturate at their maximum, and the result ports show their low 48 bits.
// Items for a digitizer beyond the configured number are ignored by count and
// clear, and a read of one returns zero counts.
//
// Items enter through a two-item command queue, so the source sees full only
// when that queue is full or while the memories are cleared after reset, and
// the result waits in an output register while the next items are taken; a
// read item stays in the queue until that register is popped. The back end
// does one read-modify-write of the level memory per sample. A read item
// loads the result register, and a clear item zeroes one bin at a time and the
// total with the first. After reset the unit clears its memories and holds full
// high meanwhile. The sample mode may be written on the configuration channel,
// which is always ready, only while the unit is idle.
module digitizer_level_histogram_unit #(
  parameter int NUM_DIGITIZERS = 4,
  parameter int COUNT_WIDTH    = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                op,
  input  logic [1:0]                digitizer,
  input  logic [7:0]                data_byte,
  input  logic [7:0]                bin_index,
  output logic                      empty,
  input  logic                      pop,
  output logic [dlh_pkg::OUT_W-1:0] level_count,
  output logic [dlh_pkg::OUT_W-1:0] sample_total,
  output logic                      bad_bin,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_data
);
  import dlh_pkg::*;

  // Handshake between the front and back: the head of the command queue.
  logic busy;
  logic head_valid;
  logic head_pop;
  cmd_t head;

  dlh_front #(.NUM_DIGITIZERS(NUM_DIGITIZERS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .digitizer  (digitizer),
    .data_byte  (data_byte),
    .bin_index  (bin_index),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .busy       (busy),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  // The back end owns both counter memories and the result register.
  dlh_back #(
    .NUM_DIGITIZERS (NUM_DIGITIZERS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .busy         (busy),
    .head_valid   (head_valid),
    .head         (head),
    .head_pop     (head_pop),
    .empty        (empty),
    .pop          (pop),
    .level_count  (level_count),
    .sample_total (sample_total),
    .bad_bin      (bad_bin)
  );

endmodule
